### hw/rtl/glp_pkg.sv
// Package for the gray Laplacian 3x3 filter: sizes, gray weights, codes and shared types.
// No dependencies; every other file of the block but glp_ram imports it.
`default_nettype none

package glp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);
  localparam int DR_W   = $clog2(MAX_WIDTH + 2);
  localparam int HT_W   = $clog2(HEIGHT_LIMIT + 1);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 3);
  localparam int RX_W   = ROW_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 13;

  localparam int PIX_W      = 8;
  localparam int MEM_W      = 2 * PIX_W;
  localparam int PROD_W     = 24;
  localparam int GRAY_SHIFT = 16;
  localparam int SUM_W      = PIX_W + 2;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam int RESET_SIZE = 128;
  localparam logic [EW_W-1:0] W_RESET =
    EW_W'((RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE);
  localparam logic [HT_W-1:0] H_RESET = HT_W'(RESET_SIZE);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic res;
    logic top_z;
    logic bot_z;
    logic left_z;
    logic right_z;
    logic fend;
  } pos_flags_t;

endpackage

`default_nettype wire

### hw/rtl/glp_if.sv
// Valid/ready channel interfaces for the pixel requests and the filter results.
// Depends on glp_pkg for the field widths.
`default_nettype none

interface glp_in_if import glp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, opcode, red, green, blue, input ready);
  modport sink   (input valid, opcode, red, green, blue, output ready);
endinterface

interface glp_out_if import glp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             frame_end;

  modport source (output valid, edge_value, frame_end, input ready);
  modport sink   (input valid, edge_value, frame_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/glp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module glp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gray_laplacian_3x3_core.sv
// Gray conversion and 4-neighbour Laplacian over a raster RGB stream, with line memory.
// Depends on glp_pkg, glp_in_if / glp_out_if and glp_ram.
//
// Usage:
//   in_req carries pixel requests (opcode pixel) in raster order and drain requests
//   (opcode drain) after the last pixel of a frame. out_res carries one clamped edge
//   value per image position in raster order; frame_end marks the last position.
//   cfg_we/cfg_index/cfg_data set image_width (index 0) and image_height (index 1);
//   any write restarts the frame position. Write only while the block is idle.
//   Throughput: one request per cycle unless a stall or a pending drain holds in_req. The
//   first drain of a single-row frame advances two positions and holds in_req meanwhile.
//   Ordering: the result for position k passes the memory stage and the output register
//   once the request bringing position k + width + 1 is accepted. width + 1 drain
//   requests deliver the rest of the frame; further drains give nothing.
//   The line memory (one entry per column, both gray rows) has one read and one
//   write a cycle; a same-column read and write in one cycle is forwarded.
//   Reset: width and height return to 128, position and window clear; the line
//   memory is not cleared, as every unpadded read hits a written entry.
//   Stall: the output register and the memory stage each hold one request, so a
//   request is still taken while a result waits; further stalling holds in_req.
`default_nettype none

module gray_laplacian_3x3_core import glp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  glp_in_if.sink                     in_req,
  glp_out_if.source                  out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [EW_W-1:0]   w_r, w_nxt;
  logic [HT_W-1:0]   h_r, h_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [DR_W-1:0]   drain_r, drain_nxt;
  logic              pend_r, pend_nxt;

  logic              s1_v_r, s1_v_nxt;
  pos_flags_t        s1_flags_r;
  logic [COL_W-1:0]  s1_addr_r;
  logic [PROD_W-1:0] s1_pr_r, s1_pg_r, s1_pb_r;
  logic              s1_fwd_r;
  logic [MEM_W-1:0]  s1_fwd_data_r;

  logic [3*PIX_W-1:0] win2_r, win2_nxt;
  logic [PIX_W-1:0]   w1mid_r, w1mid_nxt;

  logic               out_v_r, out_v_nxt;
  logic [PIX_W-1:0]   out_edge_r;
  logic               out_fend_r;

  logic               in_fire, is_pix, is_drain, do_pend, issue_free;
  logic               out_free, s1_go, row_full, drain_ok, drain_push, push;
  logic [COL_W-1:0]   ic;
  logic [ROW_W-1:0]   ir;
  logic [RX_W-1:0]    rx, hx;
  logic               c_nz;
  pos_flags_t         iflags;
  logic [EW_W-1:0]    c_inc;
  logic [PROD_W-1:0]  pr_nxt, pg_nxt, pb_nxt;

  logic [MEM_W-1:0]   ram_q, rd, wdata;
  logic [PIX_W-1:0]   up, mid, gray;
  logic [PROD_W-1:0]  gsum;
  logic [PIX_W-1:0]   top, bottom, left, right, centre;
  logic [SUM_W-1:0]   pos_sum, neg_sum, diff;
  logic [PIX_W-1:0]   edge_nxt;

  // configuration
  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data[CFG_WID_W-1:0] == '0) begin
            w_nxt = EW_W'(1);
          end else if (32'(cfg_data[CFG_WID_W-1:0]) > MAX_WIDTH) begin
            w_nxt = EW_W'(MAX_WIDTH);
          end else begin
            w_nxt = EW_W'(cfg_data[CFG_WID_W-1:0]);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data[CFG_HGT_W-1:0] == '0) begin
            h_nxt = HT_W'(1);
          end else if (32'(cfg_data[CFG_HGT_W-1:0]) > HEIGHT_LIMIT) begin
            h_nxt = HT_W'(HEIGHT_LIMIT);
          end else begin
            h_nxt = HT_W'(cfg_data[CFG_HGT_W-1:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // issue: position, padding flags and counters
  assign out_free   = !out_v_r || out_res.ready;
  assign s1_go      = s1_v_r && (!s1_flags_r.res || out_free);
  assign issue_free = !s1_v_r || s1_go;
  assign in_req.ready = issue_free && !pend_r;
  assign in_fire    = in_req.valid && in_req.ready;
  assign is_pix     = in_fire && (in_req.opcode == OP_PIXEL);
  assign is_drain   = in_fire && (in_req.opcode == OP_DRAIN);
  assign do_pend    = pend_r && issue_free;
  assign row_full   = RX_W'(row_r) >= RX_W'(h_r);
  assign drain_ok   = row_full && (drain_r <= DR_W'(w_r));
  assign drain_push = (is_drain || do_pend) && drain_ok;
  assign push       = is_pix || drain_push;

  always_comb begin
    if (is_pix && row_full) begin
      ic = '0;
      ir = '0;
    end else begin
      ic = col_r;
      ir = row_r;
    end
    rx   = RX_W'(ir);
    hx   = RX_W'(h_r);
    c_nz = ic != '0;
    if (c_nz) begin
      iflags.res   = (rx >= RX_W'(1)) && (rx <= hx);
      iflags.top_z = rx == RX_W'(1);
      iflags.bot_z = rx == hx;
    end else begin
      iflags.res   = (rx >= RX_W'(2)) && (rx <= hx + RX_W'(1));
      iflags.top_z = rx == RX_W'(2);
      iflags.bot_z = rx == hx + RX_W'(1);
    end
    iflags.fend    = !c_nz && iflags.bot_z;
    iflags.left_z  = (ic == COL_W'(1)) || (!c_nz && (w_r == EW_W'(1)));
    iflags.right_z = !c_nz;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    pend_nxt  = pend_r;
    c_inc     = EW_W'(ic) + EW_W'(1);
    if (cfg_we) begin
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
      pend_nxt  = 1'b0;
    end else if (push) begin
      if (c_inc >= w_r) begin
        col_nxt = '0;
        row_nxt = ir + ROW_W'(1);
      end else begin
        col_nxt = COL_W'(c_inc);
        row_nxt = ir;
      end
      drain_nxt = is_pix ? '0 : drain_r + DR_W'(1);
      pend_nxt  = drain_push && !iflags.res && (drain_r + DR_W'(1) <= DR_W'(w_r));
    end
  end

  always_comb begin
    if (is_pix) begin
      pr_nxt = PROD_W'(in_req.red)   * PROD_W'(W_RED);
      pg_nxt = PROD_W'(in_req.green) * PROD_W'(W_GREEN);
      pb_nxt = PROD_W'(in_req.blue)  * PROD_W'(W_BLUE);
    end else begin
      pr_nxt = '0;
      pg_nxt = '0;
      pb_nxt = '0;
    end
  end

  assign s1_v_nxt = push ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  // line memory: {older row, newer row} per column
  glp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .re    (push),
    .raddr (ic),
    .rdata (ram_q)
  );

  // memory stage: gray, window shift, Laplacian
  always_comb begin
    rd     = s1_fwd_r ? s1_fwd_data_r : ram_q;
    up     = rd[MEM_W-1:PIX_W];
    mid    = rd[PIX_W-1:0];
    gsum   = s1_pr_r + s1_pg_r + s1_pb_r;
    gray   = gsum[PROD_W-1:GRAY_SHIFT];
    wdata  = {mid, gray};

    win2_nxt  = {up, mid, gray};
    w1mid_nxt = win2_r[2*PIX_W-1:PIX_W];

    centre = win2_r[2*PIX_W-1:PIX_W];
    top    = s1_flags_r.top_z   ? '0 : win2_r[3*PIX_W-1:2*PIX_W];
    bottom = s1_flags_r.bot_z   ? '0 : win2_r[PIX_W-1:0];
    left   = s1_flags_r.left_z  ? '0 : w1mid_r;
    right  = s1_flags_r.right_z ? '0 : mid;

    pos_sum = SUM_W'(top) + SUM_W'(bottom) + SUM_W'(left) + SUM_W'(right);
    neg_sum = {centre, 2'b00};
    diff    = pos_sum - neg_sum;
    if (pos_sum < neg_sum) begin
      edge_nxt = '0;
    end else if (diff > SUM_W'(255)) begin
      edge_nxt = '1;
    end else begin
      edge_nxt = diff[PIX_W-1:0];
    end
  end

  assign out_v_nxt = (s1_go && s1_flags_r.res) ? 1'b1 : (out_res.ready ? 1'b0 : out_v_r);

  assign out_res.valid      = out_v_r;
  assign out_res.edge_value = out_edge_r;
  assign out_res.frame_end  = out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= W_RESET;
      h_r     <= H_RESET;
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
      pend_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      win2_r  <= '0;
      w1mid_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      pend_r  <= pend_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        win2_r  <= win2_nxt;
        w1mid_r <= w1mid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_flags_r    <= iflags;
      s1_addr_r     <= ic;
      s1_pr_r       <= pr_nxt;
      s1_pg_r       <= pg_nxt;
      s1_pb_r       <= pb_nxt;
      s1_fwd_r      <= s1_go && (ic == s1_addr_r);
      s1_fwd_data_r <= wdata;
    end
    if (s1_go && s1_flags_r.res) begin
      out_edge_r <= edge_nxt;
      out_fend_r <= s1_flags_r.fend;
    end
  end

endmodule

`default_nettype wire

### dv/glp_edge_checker.sv
// Edge checker: watches the request, result and register ports of the gray Laplacian core,
// predicts every edge value and frame marker, and counts mismatches against the results.
// Depends on glp_pkg and the glp_in_if / glp_out_if channel interfaces.
module glp_edge_checker import glp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  glp_in_if                     in_mon,
  glp_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending_count
);

  localparam int unsigned LUMA_R_Q16 = 13933;
  localparam int unsigned LUMA_G_Q16 = 46871;
  localparam int unsigned LUMA_B_Q16 = 4732;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_end;
  } edge_result_t;

  logic [CFG_WID_W-1:0] width_reg;
  logic [CFG_HGT_W-1:0] height_reg;
  logic [PIX_W-1:0]     older_row [MAX_WIDTH];
  logic [PIX_W-1:0]     newer_row [MAX_WIDTH];
  logic [3*PIX_W-1:0]   win_cols [3];
  int                   col_pos;
  int                   row_pos;
  int                   drained;
  edge_result_t         expected_edges [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == '0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r, g, b);
    int unsigned acc;
    acc = LUMA_R_Q16 * r + LUMA_G_Q16 * g + LUMA_B_Q16 * b;
    return PIX_W'(acc >> 16);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    error_count++;
  endtask

  // Advance one raster position with a new gray value; the result lags by one row and column.
  task automatic shift_in_gray(input logic [PIX_W-1:0] gray, output logic hit,
                               output edge_result_t res);
    int w, h, c, r, idx, cr, cc;
    int up_v, mid_v, top_v, bot_v, left_v, right_v, centre_v, acc;
    w     = eff_width();
    h     = eff_height();
    c     = col_pos;
    r     = row_pos;
    idx   = (c < MAX_WIDTH) ? c : 0;
    up_v  = int'(older_row[idx]);
    mid_v = int'(newer_row[idx]);
    older_row[idx] = PIX_W'(mid_v);
    newer_row[idx] = gray;
    win_cols[0] = win_cols[1];
    win_cols[1] = win_cols[2];
    win_cols[2] = {PIX_W'(up_v), PIX_W'(mid_v), gray};
    if (c >= 1) begin
      cr      = r - 1;
      cc      = c - 1;
      right_v = int'(win_cols[2][15:8]);
    end else begin
      cr      = r - 2;
      cc      = w - 1;
      right_v = 0;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    hit = 1'b0;
    res = '0;
    if (cr >= 0 && cr < h) begin
      centre_v = int'(win_cols[1][15:8]);
      top_v    = (cr == 0) ? 0 : int'(win_cols[1][23:16]);
      bot_v    = (cr == h - 1) ? 0 : int'(win_cols[1][7:0]);
      left_v   = (cc == 0) ? 0 : int'(win_cols[0][15:8]);
      acc      = top_v + bot_v + left_v + right_v - 4 * centre_v;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res.edge_value = PIX_W'(acc);
      res.frame_end  = (cr == h - 1) && (cc == w - 1);
      hit = 1'b1;
    end
  endtask

  always @(posedge clk) begin : model
    logic         hit;
    edge_result_t res;
    edge_result_t want;
    int           w, h;
    if (!rst_n) begin
      width_reg  = CFG_WID_W'(128);
      height_reg = CFG_HGT_W'(128);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (int i = 0; i < 3; i++) win_cols[i] = '0;
      col_pos = 0;
      row_pos = 0;
      drained = 0;
      expected_edges.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          width_reg = cfg_data[CFG_WID_W-1:0];
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_data[CFG_HGT_W-1:0];
        end
        col_pos = 0;
        row_pos = 0;
        drained = 0;
      end
      if (in_mon.valid && in_mon.ready) begin
        w   = eff_width();
        h   = eff_height();
        hit = 1'b0;
        if (in_mon.opcode == OP_PIXEL) begin
          if (row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
          end
          drained = 0;
          shift_in_gray(gray_of(in_mon.red, in_mon.green, in_mon.blue), hit, res);
        end else if (row_pos >= h) begin
          while (!hit && drained < w + 1) begin
            drained++;
            shift_in_gray('0, hit, res);
          end
        end
        if (hit) expected_edges.push_back(res);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected result edge_value=%0d frame_end=%0b",
                                    out_mon.edge_value, out_mon.frame_end));
        end else begin
          want = expected_edges.pop_front();
          if (out_mon.edge_value !== want.edge_value)
            report_mismatch($sformatf("edge_value %0d, expected %0d",
                                      out_mon.edge_value, want.edge_value));
          if (out_mon.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, expected %0b",
                                      out_mon.frame_end, want.frame_end));
        end
      end
    end
    pending_count = expected_edges.size();
  end

endmodule

### dv/tb.sv
// Top of the gray Laplacian testbench: clock, reset, pixel and drain requests, result
// back-pressure, register writes, watchdog and verdict. Checking lives in glp_edge_checker.
// Depends on glp_pkg, glp_in_if / glp_out_if, gray_laplacian_3x3_core and glp_edge_checker.
module tb import glp_pkg::*; ();

  localparam int RANDOM_ITEMS   = 620;
  localparam int BURST_WIDTH    = 40;
  localparam int BURST_HEIGHT   = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idle_on;
  int                    hold_requests;
  int                    n_errors;
  int                    n_pending;
  int                    quiet_cycles;

  glp_in_if  in_req ();
  glp_out_if out_res ();

  gray_laplacian_3x3_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glp_edge_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_req),
    .out_mon       (out_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (n_errors),
    .pending_count (n_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left     = 0;
    holds_done    = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_res.ready <= 1'b0;
        hold_left--;
      end else begin
        out_res.ready <= !(idle_on && $urandom_range(99) < 34);
      end
    end
  end

  task automatic send_request(input logic op, input logic [PIX_W-1:0] r, g, b);
    while (idle_on && $urandom_range(99) < 34) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid  <= 1'b1;
    in_req.opcode <= op;
    in_req.red    <= r;
    in_req.green  <= g;
    in_req.blue   <= b;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pixel();
    logic [PIX_W-1:0] r, g, b;
    if ($urandom_range(3) == 0) begin
      r = $urandom_range(1) ? 8'hFF : 8'h00;
      g = r;
      b = r;
    end else begin
      r = PIX_W'($urandom_range(255));
      g = PIX_W'($urandom_range(255));
      b = PIX_W'($urandom_range(255));
    end
    send_request(OP_PIXEL, r, g, b);
  endtask

  task automatic send_drain();
    send_request(OP_DRAIN, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                 PIX_W'($urandom_range(255)));
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline empty.
  task automatic settle();
    in_req.valid <= 1'b0;
    @(negedge clk);
    wait (n_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int wv, hv, w_eff, h_eff, n_pix, n_drain, noise_at, useful_items;
    bit need_cfg;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_req.valid  = 1'b0;
    in_req.opcode = OP_PIXEL;
    in_req.red    = '0;
    in_req.green  = '0;
    in_req.blue   = '0;
    idle_on       = 1'b1;
    hold_requests = 0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x3 checkerboard with primaries on the last row; early drain, extra drain
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    send_drain();
    send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd255, 8'd0, 8'd0);
    send_request(OP_PIXEL, 8'd0, 8'd255, 8'd0);
    send_request(OP_PIXEL, 8'd0, 8'd0, 8'd255);
    repeat (5) send_drain();
    send_pixel();
    send_pixel();
    send_drain();
    settle();
    // zero sizes clamp to a single pixel frame
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    repeat (2) send_drain();
    settle();

    // full frame with no idling on either side
    idle_on = 1'b0;
    write_reg(CFG_IMAGE_WIDTH, BURST_WIDTH);
    write_reg(CFG_IMAGE_HEIGHT, BURST_HEIGHT);
    repeat (BURST_WIDTH * BURST_HEIGHT) send_pixel();
    repeat (BURST_WIDTH + 1) send_drain();
    settle();
    idle_on = 1'b1;

    useful_items = 0;
    need_cfg     = 1'b1;
    w_eff        = 1;
    h_eff        = 1;
    hold_requests++;
    while (useful_items < RANDOM_ITEMS) begin
      if (need_cfg || $urandom_range(3) == 0) begin
        settle();
        case ($urandom_range(19))
          0:       wv = 0;
          1:       wv = 1;
          2, 3, 4: wv = $urandom_range(9, 40);
          default: wv = $urandom_range(2, 8);
        endcase
        case ($urandom_range(19))
          0:       hv = 0;
          1:       hv = 8191;
          2:       hv = HEIGHT_LIMIT;
          default: hv = $urandom_range(1, 6);
        endcase
        w_eff = (wv == 0) ? 1 : wv;
        h_eff = (hv == 0) ? 1 : ((hv > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hv);
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, hv);
        need_cfg = 1'b0;
      end
      idle_on = ($urandom_range(9) != 0);
      if (h_eff > 8) begin
        n_pix = $urandom_range(w_eff, 4 * w_eff);
        repeat (n_pix) send_pixel();
        send_drain();
        useful_items += n_pix;
        need_cfg = 1'b1;
      end else begin
        n_pix    = w_eff * h_eff;
        noise_at = (n_pix > 1 && $urandom_range(4) == 0) ? $urandom_range(1, n_pix - 1) : 0;
        for (int k = 1; k <= n_pix; k++) begin
          send_pixel();
          if (k == noise_at) send_drain();
        end
        case ($urandom_range(9))
          0:       n_drain = $urandom_range(0, w_eff);
          1:       n_drain = w_eff + 1 + $urandom_range(1, 3);
          default: n_drain = w_eff + 1;
        endcase
        repeat (n_drain) send_drain();
        useful_items += n_pix + ((n_drain > w_eff + 1) ? w_eff + 1 : n_drain);
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
